FILE: rtl/hce_pkg.sv
package hce_pkg;

    typedef enum logic [1:0] {
        REQ_KEY    = 2'd0,
        REQ_LETTER = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_MAC,
        ST_PUT,
        ST_ERR
    } t_state;

    localparam int unsigned KEY_DEPTH = 64;
    localparam int unsigned KEY_AW    = 6;
    localparam int unsigned KEY_STEPS = 8;
    localparam int unsigned BSIZE_RST = 2;

    localparam logic [7:0] ASCII_A  = 8'd65;
    localparam logic [7:0] ASCII_Z  = 8'd90;
    localparam logic [4:0] PAD_CODE = 5'd23;
    localparam logic [9:0] ALPHA    = 10'd26;
    localparam logic [9:0] RECIP    = 10'd315;

endpackage

FILE: rtl/hce_if.sv
interface hce_in_if import hce_pkg::*;;
    logic        valid;
    logic        ready;
    t_req        req_type;
    logic [5:0]  key_index;
    logic [29:0] key_value;
    logic [7:0]  letter;

    modport source(output valid, req_type, key_index, key_value, letter, input ready);
    modport sink(input valid, req_type, key_index, key_value, letter, output ready);
endinterface

interface hce_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;
    logic       last_of_block;
    logic       bad_letter;

    modport source(output valid, cipher_char, last_of_block, bad_letter, input ready);
    modport sink(input valid, cipher_char, last_of_block, bad_letter, output ready);
endinterface

FILE: rtl/hce_ram.sv
module hce_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/hill_cipher_encrypt_core.sv
// hill cipher encryption core, 26-letter alphabet
// channels: i_in carries key writes, plaintext letters and end-of-message
//   flushes; o_out carries cipher letters or a bad-letter error item
// i_cfg_we/i_cfg_wdata set the block size n (0 acts as 1, above MAX_N as
//   MAX_N); a write drops any open block
// a key write is accepted and then runs 8 nibble steps through the
//   shared mod-26 unit, which also serves the multiply-accumulate path
// a letter that does not close a block is only buffered; a bad letter
//   passes through the error state to the output register
// a full block runs n rows, each n multiply-accumulates through the one
//   mac pipe (key ram read, product, mod-26 accumulate) followed by a put
//   of the row's cipher letter into the output register
// i_in.ready is high only while the sequencer is idle
// results sit in one output register; when o_out.ready is low the
//   sequencer waits in front of it and nothing is lost
// reset brings n back to 2 and empties the block; key entries are
//   undefined until written
module hill_cipher_encrypt_core import hce_pkg::*; #(
    parameter int unsigned MAX_N = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    hce_in_if.sink     i_in,
    hce_out_if.source  o_out
);

    localparam int unsigned NW = $clog2(MAX_N + 1);
    localparam int unsigned CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int unsigned AW = (MAX_N * MAX_N > KEY_DEPTH) ? $clog2(MAX_N * MAX_N) : KEY_AW;

    function automatic logic [4:0] mod26(input logic [9:0] x);
        logic [18:0] t;
        logic [5:0]  q;
        logic [9:0]  r;
        t = 19'(x) * 19'(RECIP);
        q = t[18:13];
        r = x - 10'(10'(q) * ALPHA);
        if (r >= ALPHA) begin
            r = r - ALPHA;
        end
        return r[4:0];
    endfunction

    t_state          r_state, n_state;
    logic [3:0]      r_bsize, n_bsize;
    logic [NW-1:0]   r_fill, n_fill;
    logic            r_issue, n_issue;
    logic            r_v1, n_v1;
    logic            r_v2, n_v2;
    logic            r_ov, n_ov;

    logic [5:0]      r_kidx, n_kidx;
    logic [31:0]     r_kval, n_kval;
    logic [2:0]      r_step, n_step;
    logic [4:0]      r_acc, n_acc;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_col, n_col;
    logic [CW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col1;
    logic            r_oob1;
    logic            r_last1;
    logic [9:0]      r_prod;
    logic            r_last2;
    logic [6:0]      r_ochar, n_ochar;
    logic            r_olast, n_olast;
    logic            r_obad, n_obad;
    logic [4:0]      r_buf [MAX_N];

    logic [NW-1:0]   n_eff;
    logic            out_free;
    logic            letter_ok;
    logic            buf_we;
    logic [9:0]      mod_in;
    logic [4:0]      mod_out;
    logic            ram_we;
    logic [4:0]      ram_rdata;
    logic [4:0]      key_s1;
    logic [4:0]      txt_s1;

    always_comb begin
        if (r_bsize == 4'd0) begin
            n_eff = NW'(1);
        end else if (32'(r_bsize) > MAX_N) begin
            n_eff = NW'(MAX_N);
        end else begin
            n_eff = NW'(r_bsize);
        end
    end

    assign out_free  = !r_ov || o_out.ready;
    assign letter_ok = i_in.letter inside {[ASCII_A:ASCII_Z]};
    assign mod_in    = (r_state == ST_KEY) ? {1'b0, r_acc, r_kval[31:28]}
                                           : 10'(r_acc) + r_prod;
    assign mod_out   = mod26(mod_in);
    assign ram_we    = (r_state == ST_KEY) && (r_step == 3'(KEY_STEPS - 1));
    assign key_s1    = r_oob1 ? 5'd0 : ram_rdata;
    assign txt_s1    = (NW'(r_col1) < r_fill) ? r_buf[r_col1] : PAD_CODE;

    hce_ram #(
        .WIDTH(5),
        .DEPTH(KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_kidx),
        .i_wdata (mod_out),
        .i_raddr (r_addr[KEY_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_bsize = r_bsize;
        n_fill  = r_fill;
        n_issue = r_issue;
        n_v1    = 1'b0;
        n_v2    = r_v1;
        n_ov    = r_ov && !o_out.ready;
        n_kidx  = r_kidx;
        n_kval  = r_kval;
        n_step  = r_step;
        n_acc   = r_acc;
        n_addr  = r_addr;
        n_col   = r_col;
        n_row   = r_row;
        n_ochar = r_ochar;
        n_olast = r_olast;
        n_obad  = r_obad;
        buf_we  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.req_type)
                        REQ_KEY: begin
                            n_kidx  = i_in.key_index;
                            n_kval  = {2'b00, i_in.key_value};
                            n_acc   = 5'd0;
                            n_step  = 3'd0;
                            n_state = ST_KEY;
                        end
                        REQ_LETTER: begin
                            if (!letter_ok) begin
                                n_state = ST_ERR;
                            end else begin
                                buf_we = r_fill < n_eff;
                                n_fill = r_fill + NW'(1);
                                if (r_fill + NW'(1) >= n_eff) begin
                                    n_addr  = '0;
                                    n_row   = '0;
                                    n_col   = '0;
                                    n_acc   = 5'd0;
                                    n_issue = 1'b1;
                                    n_state = ST_MAC;
                                end
                            end
                        end
                        REQ_FLUSH: begin
                            if (r_fill != '0) begin
                                n_addr  = '0;
                                n_row   = '0;
                                n_col   = '0;
                                n_acc   = 5'd0;
                                n_issue = 1'b1;
                                n_state = ST_MAC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_KEY: begin
                n_acc  = mod_out;
                n_kval = {r_kval[27:0], 4'd0};
                n_step = r_step + 3'd1;
                if (ram_we) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MAC: begin
                if (r_issue) begin
                    n_v1   = 1'b1;
                    n_addr = r_addr + AW'(1);
                    n_col  = r_col + CW'(1);
                    if (NW'(r_col) + NW'(1) == n_eff) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_v2) begin
                    n_acc = mod_out;
                    if (r_last2) begin
                        n_state = ST_PUT;
                    end
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ochar = 7'(r_acc) + ASCII_A[6:0];
                    n_olast = NW'(r_row) + NW'(1) == n_eff;
                    n_obad  = 1'b0;
                    if (NW'(r_row) + NW'(1) == n_eff) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_row   = r_row + CW'(1);
                        n_col   = '0;
                        n_acc   = 5'd0;
                        n_issue = 1'b1;
                        n_state = ST_MAC;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ochar = 7'd0;
                    n_olast = 1'b0;
                    n_obad  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_bsize = i_cfg_wdata;
            n_fill  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bsize <= 4'(BSIZE_RST);
            r_fill  <= '0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bsize <= n_bsize;
            r_fill  <= n_fill;
            r_issue <= n_issue;
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kidx  <= n_kidx;
        r_kval  <= n_kval;
        r_step  <= n_step;
        r_acc   <= n_acc;
        r_addr  <= n_addr;
        r_col   <= n_col;
        r_row   <= n_row;
        r_col1  <= r_col;
        r_oob1  <= 32'(r_addr) >= KEY_DEPTH;
        r_last1 <= NW'(r_col) + NW'(1) == n_eff;
        r_prod  <= 10'(key_s1) * 10'(txt_s1);
        r_last2 <= r_last1;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_obad  <= n_obad;
        if (buf_we) begin
            r_buf[r_fill[CW-1:0]] <= i_in.letter[4:0] - ASCII_A[4:0];
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.cipher_char   = r_ochar;
    assign o_out.last_of_block = r_olast;
    assign o_out.bad_letter    = r_obad;

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_v1 && !r_v2 && !r_issue))
        else $error("mac pipe busy while idle");

    a_idle_fill_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill < n_eff))
        else $error("full block left unsent");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC || r_state == ST_PUT) |-> (NW'(r_row) < n_eff))
        else $error("row count past block size");

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_letter) |->
            (o_out.cipher_char == 7'd0 && !o_out.last_of_block))
        else $error("error item carries a letter");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.bad_letter) |->
            (o_out.cipher_char >= 7'd65 && o_out.cipher_char <= 7'd90))
        else $error("cipher letter out of range");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT && out_free && NW'(r_row) + NW'(1) == n_eff) |=>
            (r_state == ST_IDLE && r_fill == '0 && o_out.last_of_block))
        else $error("block end not closed");

endmodule
